@@ sv/tpfc_pkg.sv @@
package tpfc_pkg;

   // Empty-event plane point, in cm, and the fixed-point scale
   localparam int EMPTY_MARK_CM = -9999;
   localparam int UNITS_PER_CM  = 256;

   // Entries between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PLANE_Z     = 3'd0,
      CSR_BOX_X_LOW   = 3'd1,
      CSR_BOX_X_HIGH  = 3'd2,
      CSR_BOX_Y_LOW   = 3'd3,
      CSR_BOX_Y_HIGH  = 3'd4,
      CSR_REQUIRE_ALL = 3'd5
   } tpfc_csr_type;

   // Track class decided at the front
   typedef enum logic [1:0] {
      OP_TRACK = 2'd0,
      OP_FLAT  = 2'd1,
      OP_EMPTY = 2'd2
   } tpfc_op_type;

   typedef struct packed {
      tpfc_op_type op;
      logic        last;
   } tpfc_ctl_type;

   // Back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_MUL      = 3'd1,
      ST_DIV_LOAD = 3'd2,
      ST_DIV      = 3'd3,
      ST_ROUND    = 3'd4,
      ST_FINISH   = 3'd5
   } tpfc_state_type;

endpackage

@@ sv/tpfc_if.sv @@
interface tpfc_req_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] begin_x;
   logic signed [COORD_WIDTH-1:0] begin_y;
   logic signed [COORD_WIDTH-1:0] begin_z;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic signed [COORD_WIDTH-1:0] end_z;
   logic                          last_track;
   logic                          empty_event;

   modport source (
      output valid, begin_x, begin_y, begin_z, end_x, end_y, end_z, last_track, empty_event,
      input  ready
   );
   modport sink (
      input  valid, begin_x, begin_y, begin_z, end_x, end_y, end_z, last_track, empty_event,
      output ready
   );
endinterface

interface tpfc_rsp_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic                          event_passed;
   logic signed [COORD_WIDTH-1:0] plane_x;
   logic signed [COORD_WIDTH-1:0] plane_y;

   modport source (
      output valid, event_passed, plane_x, plane_y,
      input  ready
   );
   modport sink (
      input  valid, event_passed, plane_x, plane_y,
      output ready
   );
endinterface

@@ sv/tpfc_front.sv @@
module tpfc_front #(
   parameter int COORD_WIDTH = 24
) (
   tpfc_req_if.sink                              req_bus,
   input  logic signed [COORD_WIDTH-1:0]         plane_z,
   input  logic                                  q_full,
   output logic                                  push,
   output tpfc_pkg::tpfc_ctl_type                push_ctl,
   output logic [2*COORD_WIDTH+4*(COORD_WIDTH+1)-1:0] push_data
);

   logic signed [COORD_WIDTH:0] num_x;
   logic signed [COORD_WIDTH:0] num_y;
   logic signed [COORD_WIDTH:0] dp;
   logic signed [COORD_WIDTH:0] dz;

   // Accept whenever the queue has room
   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full;

   // Form the deltas one bit wider than the coordinates
   assign num_x = $signed({req_bus.end_x[COORD_WIDTH-1], req_bus.end_x})
                - $signed({req_bus.begin_x[COORD_WIDTH-1], req_bus.begin_x});
   assign num_y = $signed({req_bus.end_y[COORD_WIDTH-1], req_bus.end_y})
                - $signed({req_bus.begin_y[COORD_WIDTH-1], req_bus.begin_y});
   assign dp    = $signed({plane_z[COORD_WIDTH-1], plane_z})
                - $signed({req_bus.begin_z[COORD_WIDTH-1], req_bus.begin_z});
   assign dz    = $signed({req_bus.end_z[COORD_WIDTH-1], req_bus.end_z})
                - $signed({req_bus.begin_z[COORD_WIDTH-1], req_bus.begin_z});

   // Classify: empty event, track parallel to the plane, or a real track
   always_comb begin
      push_ctl.last = req_bus.last_track;
      if (req_bus.empty_event) begin
         push_ctl.op = tpfc_pkg::OP_EMPTY;
      end else if (dz == '0) begin
         push_ctl.op = tpfc_pkg::OP_FLAT;
      end else begin
         push_ctl.op = tpfc_pkg::OP_TRACK;
      end
   end

   assign push_data = {req_bus.begin_x, req_bus.begin_y, num_x, num_y, dp, dz};

endmodule

@@ sv/tpfc_queue.sv @@
module tpfc_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tpfc_pkg::tpfc_ctl_type push_ctl,
   input  logic [DATA_WIDTH-1:0]  push_data,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output tpfc_pkg::tpfc_ctl_type head_ctl,
   output logic [DATA_WIDTH-1:0]  head_data
);

   localparam int Depth      = tpfc_pkg::QUEUE_DEPTH;
   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   tpfc_pkg::tpfc_ctl_type slot_ctl_ff  [Depth];
   logic [DATA_WIDTH-1:0]  slot_data_ff [Depth];

   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full      = (count_ff == CountWidth'(Depth));
   assign empty     = (count_ff == '0);
   assign head_ctl  = slot_ctl_ff[rd_ptr_ff];
   assign head_data = slot_data_ff[rd_ptr_ff];

   // Advance pointers with wrap, track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ctl_ff[wr_ptr_ff]  <= push_ctl;
         slot_data_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("queue fill level above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CountWidth'(1))
      else $error("queue fill level did not grow on push");

endmodule

@@ sv/tpfc_back.sv @@
module tpfc_back #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  tpfc_pkg::tpfc_ctl_type                head_ctl,
   input  logic [2*COORD_WIDTH+4*(COORD_WIDTH+1)-1:0] head_data,
   output logic                                  pop,
   input  logic signed [COORD_WIDTH-1:0]         box_x_low,
   input  logic signed [COORD_WIDTH-1:0]         box_x_high,
   input  logic signed [COORD_WIDTH-1:0]         box_y_low,
   input  logic signed [COORD_WIDTH-1:0]         box_y_high,
   input  logic                                  require_all,
   tpfc_rsp_if.source                            rsp_bus
);

   localparam int ProdWidth = 2 * COORD_WIDTH + 2;
   localparam int CntWidth  = $clog2(COORD_WIDTH + 1);
   localparam longint MarkFull = longint'(tpfc_pkg::EMPTY_MARK_CM)
                               * longint'(tpfc_pkg::UNITS_PER_CM);
   localparam longint CoordMin = -(longint'(1) <<< (COORD_WIDTH - 1));
   localparam logic [COORD_WIDTH-1:0] EmptyMark =
      (MarkFull < CoordMin) ? COORD_WIDTH'(CoordMin) : COORD_WIDTH'(MarkFull);

   // |v| of a delta, fits unsigned in the same width
   function automatic logic [COORD_WIDTH:0] mag(input logic [COORD_WIDTH:0] v);
      return v[COORD_WIDTH] ? (~v + 1'b1) : v;
   endfunction

   // Apply sign to the quotient, add to the start point and saturate
   function automatic logic [COORD_WIDTH-1:0] settle(
      input logic [COORD_WIDTH-1:0] b,
      input logic [COORD_WIDTH-1:0] q,
      input logic                   ovf,
      input logic                   neg
   );
      logic [COORD_WIDTH:0]          qs;
      logic signed [COORD_WIDTH+1:0] off;
      logic signed [COORD_WIDTH+1:0] sum;
      qs  = ovf ? {1'b1, {COORD_WIDTH{1'b0}}} : {1'b0, q};
      off = neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
      sum = $signed({{2{b[COORD_WIDTH-1]}}, b}) + off;
      if (sum[COORD_WIDTH+1:COORD_WIDTH-1] == '0 || sum[COORD_WIDTH+1:COORD_WIDTH-1] == '1) begin
         return sum[COORD_WIDTH-1:0];
      end else if (sum[COORD_WIDTH+1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   // Queue head fields
   logic [COORD_WIDTH-1:0] h_begin_x, h_begin_y;
   logic [COORD_WIDTH:0]   h_num_x, h_num_y, h_dp, h_dz;
   assign {h_begin_x, h_begin_y, h_num_x, h_num_y, h_dp, h_dz} = head_data;

   tpfc_pkg::tpfc_state_type state_ff, state_in;
   tpfc_pkg::tpfc_op_type    op_ff, op_in;
   logic                     last_ff, last_in;
   logic [COORD_WIDTH-1:0]   begin_x_ff, begin_x_in, begin_y_ff, begin_y_in;
   logic [COORD_WIDTH:0]     mnum_x_ff, mnum_x_in, mnum_y_ff, mnum_y_in;
   logic [COORD_WIDTH:0]     mdp_ff, mdp_in, dmag_ff, dmag_in;
   logic                     neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [ProdWidth-1:0]     prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [COORD_WIDTH:0]     rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [COORD_WIDTH-1:0]   low_x_ff, low_x_in, low_y_ff, low_y_in;
   logic                     ovf_x_ff, ovf_x_in, ovf_y_ff, ovf_y_in;
   logic [CntWidth-1:0]      count_ff, count_in;
   logic [COORD_WIDTH-1:0]   cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic                     verdict_ff, verdict_in;
   logic                     first_ff, first_in;
   logic                     stopped_ff, stopped_in;
   logic [COORD_WIDTH-1:0]   held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_passed_ff, rsp_passed_in;
   logic [COORD_WIDTH-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // Divider step and finish-stage helpers
   logic [COORD_WIDTH+1:0]      trial_x, trial_y, diff_x, diff_y;
   logic                        ge_x, ge_y;
   logic signed [COORD_WIDTH-1:0] point_x, point_y;
   logic                        in_box;
   logic                        emit;
   logic                        v_next, s_next, s_start;

   assign trial_x = {rem_x_ff, low_x_ff[COORD_WIDTH-1]};
   assign trial_y = {rem_y_ff, low_y_ff[COORD_WIDTH-1]};
   assign ge_x    = trial_x >= {1'b0, dmag_ff};
   assign ge_y    = trial_y >= {1'b0, dmag_ff};
   assign diff_x  = trial_x - {1'b0, dmag_ff};
   assign diff_y  = trial_y - {1'b0, dmag_ff};

   // Plane point and box test of the current track
   assign point_x = (op_ff == tpfc_pkg::OP_TRACK) ? $signed(cand_x_ff) : $signed(EmptyMark);
   assign point_y = (op_ff == tpfc_pkg::OP_TRACK) ? $signed(cand_y_ff) : $signed(EmptyMark);
   assign in_box  = (op_ff == tpfc_pkg::OP_TRACK)
                 && point_x >= box_x_low && point_x <= box_x_high
                 && point_y >= box_y_low && point_y <= box_y_high;
   assign emit    = (op_ff == tpfc_pkg::OP_EMPTY) || last_ff;

   // Fold the track into the event verdict
   always_comb begin
      s_start = first_ff ? 1'b0 : stopped_ff;
      v_next  = first_ff ? require_all : verdict_ff;
      s_next  = s_start;
      if (!s_start) begin
         if (require_all) begin
            v_next = v_next && in_box;
            s_next = !in_box;
         end else begin
            v_next = v_next || in_box;
         end
      end
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      begin_x_in    = begin_x_ff;
      begin_y_in    = begin_y_ff;
      mnum_x_in     = mnum_x_ff;
      mnum_y_in     = mnum_y_ff;
      mdp_in        = mdp_ff;
      dmag_in       = dmag_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      prod_x_in     = prod_x_ff;
      prod_y_in     = prod_y_ff;
      rem_x_in      = rem_x_ff;
      rem_y_in      = rem_y_ff;
      low_x_in      = low_x_ff;
      low_y_in      = low_y_ff;
      ovf_x_in      = ovf_x_ff;
      ovf_y_in      = ovf_y_ff;
      count_in      = count_ff;
      cand_x_in     = cand_x_ff;
      cand_y_in     = cand_y_ff;
      verdict_in    = verdict_ff;
      first_in      = first_ff;
      stopped_in    = stopped_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_passed_in = rsp_passed_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      pop           = 1'b0;

      case (state_ff)
         tpfc_pkg::ST_IDLE: begin
            // Take the next entry; math only for real tracks before an all-mode stop
            if (!q_empty) begin
               pop        = 1'b1;
               op_in      = head_ctl.op;
               last_in    = head_ctl.last;
               begin_x_in = h_begin_x;
               begin_y_in = h_begin_y;
               mnum_x_in  = mag(h_num_x);
               mnum_y_in  = mag(h_num_y);
               mdp_in     = mag(h_dp);
               dmag_in    = mag(h_dz);
               neg_x_in   = h_num_x[COORD_WIDTH] ^ h_dp[COORD_WIDTH] ^ h_dz[COORD_WIDTH];
               neg_y_in   = h_num_y[COORD_WIDTH] ^ h_dp[COORD_WIDTH] ^ h_dz[COORD_WIDTH];
               if (head_ctl.op == tpfc_pkg::OP_TRACK && !(stopped_ff && !first_ff)) begin
                  state_in = tpfc_pkg::ST_MUL;
               end else begin
                  state_in = tpfc_pkg::ST_FINISH;
               end
            end
         end
         tpfc_pkg::ST_MUL: begin
            prod_x_in = ProdWidth'(mnum_x_ff) * ProdWidth'(mdp_ff);
            prod_y_in = ProdWidth'(mnum_y_ff) * ProdWidth'(mdp_ff);
            state_in  = tpfc_pkg::ST_DIV_LOAD;
         end
         tpfc_pkg::ST_DIV_LOAD: begin
            // Upper half at or above the divisor means the quotient saturates
            ovf_x_in = prod_x_ff[ProdWidth-1:COORD_WIDTH] >= (COORD_WIDTH+2)'(dmag_ff);
            ovf_y_in = prod_y_ff[ProdWidth-1:COORD_WIDTH] >= (COORD_WIDTH+2)'(dmag_ff);
            rem_x_in = prod_x_ff[2*COORD_WIDTH:COORD_WIDTH];
            rem_y_in = prod_y_ff[2*COORD_WIDTH:COORD_WIDTH];
            low_x_in = prod_x_ff[COORD_WIDTH-1:0];
            low_y_in = prod_y_ff[COORD_WIDTH-1:0];
            count_in = CntWidth'(COORD_WIDTH);
            state_in = tpfc_pkg::ST_DIV;
         end
         tpfc_pkg::ST_DIV: begin
            // One restoring step per axis per cycle
            rem_x_in = ge_x ? diff_x[COORD_WIDTH:0] : trial_x[COORD_WIDTH:0];
            rem_y_in = ge_y ? diff_y[COORD_WIDTH:0] : trial_y[COORD_WIDTH:0];
            low_x_in = {low_x_ff[COORD_WIDTH-2:0], ge_x};
            low_y_in = {low_y_ff[COORD_WIDTH-2:0], ge_y};
            count_in = count_ff - 1'b1;
            if (count_ff == CntWidth'(1)) begin
               state_in = tpfc_pkg::ST_ROUND;
            end
         end
         tpfc_pkg::ST_ROUND: begin
            cand_x_in = settle(begin_x_ff, low_x_ff, ovf_x_ff, neg_x_ff);
            cand_y_in = settle(begin_y_ff, low_y_ff, ovf_y_ff, neg_y_ff);
            state_in  = tpfc_pkg::ST_FINISH;
         end
         tpfc_pkg::ST_FINISH: begin
            // Hold while a result is due and the output register is still full
            if (!emit || !rsp_valid_ff || rsp_bus.ready) begin
               state_in = tpfc_pkg::ST_IDLE;
               if (op_ff == tpfc_pkg::OP_EMPTY) begin
                  first_in      = 1'b1;
                  stopped_in    = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_passed_in = !require_all;
                  rsp_x_in      = EmptyMark;
                  rsp_y_in      = EmptyMark;
               end else begin
                  verdict_in = v_next;
                  stopped_in = s_next;
                  first_in   = last_ff;
                  if (!s_start) begin
                     held_x_in = point_x;
                     held_y_in = point_y;
                  end
                  if (last_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_passed_in = v_next;
                     rsp_x_in      = s_start ? held_x_ff : point_x;
                     rsp_y_in      = s_start ? held_y_ff : point_y;
                  end
               end
            end
         end
         default: begin
            state_in = tpfc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpfc_pkg::ST_IDLE;
         verdict_ff   <= 1'b0;
         first_ff     <= 1'b1;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         verdict_ff   <= verdict_in;
         first_ff     <= first_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      last_ff       <= last_in;
      begin_x_ff    <= begin_x_in;
      begin_y_ff    <= begin_y_in;
      mnum_x_ff     <= mnum_x_in;
      mnum_y_ff     <= mnum_y_in;
      mdp_ff        <= mdp_in;
      dmag_ff       <= dmag_in;
      neg_x_ff      <= neg_x_in;
      neg_y_ff      <= neg_y_in;
      prod_x_ff     <= prod_x_in;
      prod_y_ff     <= prod_y_in;
      rem_x_ff      <= rem_x_in;
      rem_y_ff      <= rem_y_in;
      low_x_ff      <= low_x_in;
      low_y_ff      <= low_y_in;
      ovf_x_ff      <= ovf_x_in;
      ovf_y_ff      <= ovf_y_in;
      count_ff      <= count_in;
      cand_x_ff     <= cand_x_in;
      cand_y_ff     <= cand_y_in;
      held_x_ff     <= held_x_in;
      held_y_ff     <= held_y_in;
      rsp_passed_ff <= rsp_passed_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.event_passed = rsp_passed_ff;
   assign rsp_bus.plane_x      = rsp_x_ff;
   assign rsp_bus.plane_y      = rsp_y_ff;

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpfc_pkg::ST_DIV |-> count_ff != '0)
      else $error("divider running with zero step count");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tpfc_pkg::ST_FINISH))
      else $error("result raised outside the finish step");

   a_stop_all_mode: assert property (@(posedge clock) disable iff (reset)
      $rose(stopped_ff) |-> $past(require_all))
      else $error("early stop set in any-track mode");

endmodule

@@ sv/track_plane_fiducial_check_core.sv @@
// Track plane fiducial check.
// req_bus carries one track per transaction (start and stop points, last_track,
// empty_event); rsp_bus carries one result per event: the verdict and the plane
// point of the last evaluated track. Both use valid/ready; a transaction moves
// when both are high. The csr_ port writes plane_z, the x/y box and
// require_all. The user must write them only while the block is idle;
// the block itself does not enforce it. In the back end a track through
// the plane passes a dispatch step, a multiply step, a divider load, one
// restoring divider step per quotient bit (COORD_WIDTH steps, both axes in
// parallel), a rounding step and a finish step. Empty events, tracks
// parallel to the plane and tracks skipped after an all-mode failure go
// from dispatch straight to the finish step.
// A two-entry queue sits between the front and the back, so new tracks are
// taken while the back end works or a result waits. When rsp_bus.ready is
// low the result holds in its output register; the back end stalls only when
// it has a further result to give, and then the queue fills and req_bus.ready
// drops. Reset empties the queue, drops the output valid, restarts the event
// state and clears all configuration registers to zero.
module track_plane_fiducial_check_core #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   tpfc_req_if.sink                               req_bus,
   tpfc_rsp_if.source                             rsp_bus,
   input  logic                                   csr_write_enable,
   input  logic [tpfc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_write_data
);

   localparam int DataWidth = 2 * COORD_WIDTH + 4 * (COORD_WIDTH + 1);

   logic signed [COORD_WIDTH-1:0] plane_z_ff, plane_z_in;
   logic signed [COORD_WIDTH-1:0] box_x_low_ff, box_x_low_in;
   logic signed [COORD_WIDTH-1:0] box_x_high_ff, box_x_high_in;
   logic signed [COORD_WIDTH-1:0] box_y_low_ff, box_y_low_in;
   logic signed [COORD_WIDTH-1:0] box_y_high_ff, box_y_high_in;
   logic                          require_all_ff, require_all_in;

   logic                   push, pop, q_full, q_empty;
   tpfc_pkg::tpfc_ctl_type push_ctl, head_ctl;
   logic [DataWidth-1:0]   push_data, head_data;

   // Decode configuration writes; unknown indexes are dropped
   always_comb begin
      plane_z_in     = plane_z_ff;
      box_x_low_in   = box_x_low_ff;
      box_x_high_in  = box_x_high_ff;
      box_y_low_in   = box_y_low_ff;
      box_y_high_in  = box_y_high_ff;
      require_all_in = require_all_ff;
      if (csr_write_enable) begin
         case (tpfc_pkg::tpfc_csr_type'(csr_index))
            tpfc_pkg::CSR_PLANE_Z:     plane_z_in     = csr_write_data;
            tpfc_pkg::CSR_BOX_X_LOW:   box_x_low_in   = csr_write_data;
            tpfc_pkg::CSR_BOX_X_HIGH:  box_x_high_in  = csr_write_data;
            tpfc_pkg::CSR_BOX_Y_LOW:   box_y_low_in   = csr_write_data;
            tpfc_pkg::CSR_BOX_Y_HIGH:  box_y_high_in  = csr_write_data;
            tpfc_pkg::CSR_REQUIRE_ALL: require_all_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_z_ff     <= '0;
         box_x_low_ff   <= '0;
         box_x_high_ff  <= '0;
         box_y_low_ff   <= '0;
         box_y_high_ff  <= '0;
         require_all_ff <= 1'b0;
      end else begin
         plane_z_ff     <= plane_z_in;
         box_x_low_ff   <= box_x_low_in;
         box_x_high_ff  <= box_x_high_in;
         box_y_low_ff   <= box_y_low_in;
         box_y_high_ff  <= box_y_high_in;
         require_all_ff <= require_all_in;
      end
   end

   tpfc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .req_bus   (req_bus),
      .plane_z   (plane_z_ff),
      .q_full    (q_full),
      .push      (push),
      .push_ctl  (push_ctl),
      .push_data (push_data)
   );

   tpfc_queue #(
      .DATA_WIDTH (DataWidth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ctl  (push_ctl),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_ctl  (head_ctl),
      .head_data (head_data)
   );

   tpfc_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .head_ctl    (head_ctl),
      .head_data   (head_data),
      .pop         (pop),
      .box_x_low   (box_x_low_ff),
      .box_x_high  (box_x_high_ff),
      .box_y_low   (box_y_low_ff),
      .box_y_high  (box_y_high_ff),
      .require_all (require_all_ff),
      .rsp_bus     (rsp_bus)
   );

endmodule

@@ test/track_plane_fiducial_check_core_test.sv @@
module track_plane_fiducial_check_core_test;

   localparam int COORD_WIDTH = 24;
   localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam longint unsigned QUOT_CAP = longint'(1) << 40;
   localparam int SETTLE_CYCLES = COORD_WIDTH + 16;
   localparam int ITEMS_PER_SEGMENT = 150;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type begin_x;
      coord_type begin_y;
      coord_type begin_z;
      coord_type end_x;
      coord_type end_y;
      coord_type end_z;
      logic      last_track;
      logic      empty_event;
   } track_item_type;

   typedef struct packed {
      logic      event_passed;
      coord_type plane_x;
      coord_type plane_y;
   } verdict_item_type;

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Event verdict tracker: mirrors the cut settings and the per-event state
   class fiducial_scoreboard;
      longint plane_z, box_x_low, box_x_high, box_y_low, box_y_high;
      bit require_all;
      bit verdict_so_far, first_in_event, stopped_early;
      longint held_x, held_y;
      verdict_item_type expected_verdicts[$];
      int failures;

      function new();
         first_in_event = 1'b1;
      endfunction

      function void write_reg(tpfc_pkg::tpfc_csr_type idx, logic [COORD_WIDTH-1:0] data);
         case (idx)
            tpfc_pkg::CSR_PLANE_Z:     plane_z = longint'(coord_type'(data));
            tpfc_pkg::CSR_BOX_X_LOW:   box_x_low = longint'(coord_type'(data));
            tpfc_pkg::CSR_BOX_X_HIGH:  box_x_high = longint'(coord_type'(data));
            tpfc_pkg::CSR_BOX_Y_LOW:   box_y_low = longint'(coord_type'(data));
            tpfc_pkg::CSR_BOX_Y_HIGH:  box_y_high = longint'(coord_type'(data));
            tpfc_pkg::CSR_REQUIRE_ALL: require_all = data[0];
            default: ;
         endcase
      endfunction

      function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      // Extend one axis to the plane: exact product, truncated quotient, capped
      function longint extend_axis(longint b, longint e, longint dz, longint dp);
         longint num;
         bit neg;
         longint unsigned q;
         num = e - b;
         neg = (num < 0) != (dp < 0);
         if (dz < 0) neg = !neg;
         q = (magnitude(num) * magnitude(dp)) / magnitude(dz);
         if (q > QUOT_CAP) q = QUOT_CAP;
         return clamp_coord(b + (neg ? -longint'(q) : longint'(q)));
      endfunction

      function longint empty_mark();
         return clamp_coord(longint'(tpfc_pkg::EMPTY_MARK_CM) * tpfc_pkg::UNITS_PER_CM);
      endfunction

      // Fold one accepted track into the event and queue the verdict at its end
      function void note_track(track_item_type t);
         longint bz, dz, dp;
         bit in_box;
         verdict_item_type v;
         if (t.empty_event) begin
            first_in_event = 1'b1;
            stopped_early = 1'b0;
            v.event_passed = !require_all;
            v.plane_x = coord_type'(empty_mark());
            v.plane_y = coord_type'(empty_mark());
            expected_verdicts = {expected_verdicts, v};
            return;
         end
         if (first_in_event) begin
            verdict_so_far = require_all;
            stopped_early = 1'b0;
            first_in_event = 1'b0;
         end
         if (!stopped_early) begin
            bz = longint'(t.begin_z);
            dz = longint'(t.end_z) - bz;
            in_box = 1'b0;
            if (dz == 0) begin
               // parallel to the plane: never in the box
               held_x = empty_mark();
               held_y = empty_mark();
            end else begin
               dp = plane_z - bz;
               held_x = extend_axis(longint'(t.begin_x), longint'(t.end_x), dz, dp);
               held_y = extend_axis(longint'(t.begin_y), longint'(t.end_y), dz, dp);
               in_box = held_x >= box_x_low && held_x <= box_x_high &&
                        held_y >= box_y_low && held_y <= box_y_high;
            end
            if (require_all) begin
               verdict_so_far = verdict_so_far && in_box;
               if (!in_box) stopped_early = 1'b1;
            end else begin
               verdict_so_far = verdict_so_far || in_box;
            end
         end
         if (!t.last_track) return;
         first_in_event = 1'b1;
         v.event_passed = verdict_so_far;
         v.plane_x = coord_type'(held_x);
         v.plane_y = coord_type'(held_y);
         expected_verdicts = {expected_verdicts, v};
      endfunction

      // Compare a result transaction with the oldest queued verdict
      function void check_result(verdict_item_type got);
         verdict_item_type want;
         if (expected_verdicts.size() == 0) begin
            $error("result with no event pending: passed %0d x %0d y %0d",
                   got.event_passed, got.plane_x, got.plane_y);
            failures++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.event_passed !== want.event_passed) begin
            $error("event_passed mismatch: expected %0d, actual %0d",
                   want.event_passed, got.event_passed);
            failures++;
         end
         if (got.plane_x !== want.plane_x) begin
            $error("plane_x mismatch: expected %0d, actual %0d", want.plane_x, got.plane_x);
            failures++;
         end
         if (got.plane_y !== want.plane_y) begin
            $error("plane_y mismatch: expected %0d, actual %0d", want.plane_y, got.plane_y);
            failures++;
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic [tpfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [COORD_WIDTH-1:0] csr_write_data;

   tpfc_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_bus ();
   tpfc_rsp_if #(.COORD_WIDTH(COORD_WIDTH)) rsp_bus ();

   fiducial_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int sent_tracks;

   track_plane_fiducial_check_core #(.COORD_WIDTH(COORD_WIDTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Stop a hung run
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic longint spread(int unsigned span);
      return longint'($urandom_range(0, 2 * span)) - longint'(span);
   endfunction

   function automatic longint any_coord();
      case ($urandom_range(9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return 0;
         3: return -1;
         default: return longint'(coord_type'($urandom()));
      endcase
   endfunction

   // Aim near the box: its edges, one step outside, in between, or near lo if inverted
   function automatic longint pick_target(longint lo, longint hi);
      case ($urandom_range(9))
         0: return clamp_coord(lo - 1);
         1: return lo;
         2: return hi;
         3: return clamp_coord(hi + 1);
         default: begin
            if (lo <= hi) return lo + longint'($urandom_range(0, 32'(hi - lo)));
            return clamp_coord(lo + spread(4096));
         end
      endcase
   endfunction

   function automatic track_item_type make_track(longint bx, longint by, longint bz,
                                                 longint ex, longint ey, longint ez,
                                                 bit last);
      track_item_type t;
      t.begin_x = coord_type'(bx);
      t.begin_y = coord_type'(by);
      t.begin_z = coord_type'(bz);
      t.end_x = coord_type'(ex);
      t.end_y = coord_type'(ey);
      t.end_z = coord_type'(ez);
      t.last_track = last;
      t.empty_event = 1'b0;
      return t;
   endfunction

   // Symmetric about the plane, so the line crosses it at (tx, ty) unless a point is clamped
   function automatic track_item_type track_at(longint tx, longint ty, bit last);
      longint d, kx, ky;
      d = $urandom_range(1, 1 << 14);
      kx = spread(1 << 15);
      ky = spread(1 << 15);
      if ($urandom_range(1)) d = -d;
      return make_track(clamp_coord(tx - kx), clamp_coord(ty - ky),
                        clamp_coord(sb.plane_z - d), clamp_coord(tx + kx),
                        clamp_coord(ty + ky), clamp_coord(sb.plane_z + d), last);
   endfunction

   function automatic track_item_type random_track(bit last);
      track_item_type t;
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         t = track_at(pick_target(sb.box_x_low, sb.box_x_high),
                      pick_target(sb.box_y_low, sb.box_y_high), last);
      end else begin
         t = make_track(any_coord(), any_coord(), any_coord(),
                        any_coord(), any_coord(), any_coord(), last);
         if (pick < 65) t.end_z = t.begin_z;
      end
      return t;
   endfunction

   function automatic track_item_type empty_item();
      track_item_type t;
      t = make_track(any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), $urandom_range(1));
      t.empty_event = 1'b1;
      return t;
   endfunction

   // Offer one track transaction, with random idle cycles ahead of it
   task automatic offer_track(track_item_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.begin_x <= t.begin_x;
      req_bus.begin_y <= t.begin_y;
      req_bus.begin_z <= t.begin_z;
      req_bus.end_x <= t.end_x;
      req_bus.end_y <= t.end_y;
      req_bus.end_z <= t.end_z;
      req_bus.last_track <= t.last_track;
      req_bus.empty_event <= t.empty_event;
      do @(negedge clock); while (req_bus.ready !== 1'b1);
      @(posedge clock);
      sb.note_track(t);
      sent_tracks++;
   endtask

   task automatic send_event(int track_count);
      for (int i = 0; i < track_count; i++) begin
         // now and then drop the partial event with an empty-event marker
         if (i > 0 && $urandom_range(99) < 3) offer_track(empty_item());
         offer_track(random_track(i == track_count - 1));
      end
   endtask

   // Pause input until every verdict is back and the back end has settled
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(tpfc_pkg::tpfc_csr_type idx, longint value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[COORD_WIDTH-1:0];
      @(posedge clock);
      sb.write_reg(idx, value[COORD_WIDTH-1:0]);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(longint plane, longint xl, longint xh,
                                 longint yl, longint yh, bit need_all);
      write_reg(tpfc_pkg::CSR_PLANE_Z, plane);
      write_reg(tpfc_pkg::CSR_BOX_X_LOW, xl);
      write_reg(tpfc_pkg::CSR_BOX_X_HIGH, xh);
      write_reg(tpfc_pkg::CSR_BOX_Y_LOW, yl);
      write_reg(tpfc_pkg::CSR_BOX_Y_HIGH, yh);
      write_reg(tpfc_pkg::CSR_REQUIRE_ALL, longint'(need_all));
   endtask

   // Result side: random back-pressure, long hold-off on request, check on accept
   initial begin : result_sink
      verdict_item_type got;
      bit taken;
      taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (taken) sb.check_result(got);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
         @(negedge clock);
         taken = rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1 && !reset;
         got.event_passed = rsp_bus.event_passed;
         got.plane_x = rsp_bus.plane_x;
         got.plane_y = rsp_bus.plane_y;
      end
   end

   initial begin : stimulus
      track_item_type t;
      int start;
      longint plane, cx, cy, hx, hy;

      req_bus.valid <= 1'b0;
      req_bus.begin_x <= '0;
      req_bus.begin_y <= '0;
      req_bus.begin_z <= '0;
      req_bus.end_x <= '0;
      req_bus.end_y <= '0;
      req_bus.end_z <= '0;
      req_bus.last_track <= 1'b0;
      req_bus.empty_event <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      send_idle_pct = 26;
      recv_idle_pct = 49;
      hold_cycles = 0;
      sent_tracks = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: any-track mode, box x in [-1000, 1000], y in [-500, 500], plane at 10 cm
      write_settings(2560, -1000, 1000, -500, 500, 1'b0);
      t = empty_item();
      t.last_track = 1'b1;
      offer_track(t);
      offer_track(track_at(0, 0, 1'b1));
      offer_track(make_track(5, 5, 100, 50, 50, 100, 1'b1));
      offer_track(track_at(5000, 0, 1'b0));
      offer_track(track_at(1000, -500, 1'b1));
      offer_track(track_at(1001, 0, 1'b1));
      offer_track(track_at(0, 501, 1'b1));
      offer_track(make_track(COORD_MAX, COORD_MAX, COORD_MAX,
                             COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
      offer_track(make_track(COORD_MIN, COORD_MIN, COORD_MIN,
                             COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
      // partial event dropped by an empty-event marker
      offer_track(track_at(0, 0, 1'b0));
      t = empty_item();
      t.last_track = 1'b0;
      offer_track(t);
      offer_track(track_at(9999, 0, 1'b1));

      // All-track mode: empty fails, tracks after the first miss are skipped
      drain();
      write_reg(tpfc_pkg::CSR_REQUIRE_ALL, 1);
      t = empty_item();
      t.last_track = 1'b1;
      offer_track(t);
      offer_track(track_at(0, 0, 1'b0));
      offer_track(track_at(2000, 0, 1'b0));
      offer_track(track_at(0, 0, 1'b1));
      offer_track(track_at(-1000, 500, 1'b0));
      offer_track(track_at(1000, -500, 1'b1));
      // switch mode in the middle of an event
      offer_track(track_at(0, 0, 1'b0));
      drain();
      write_reg(tpfc_pkg::CSR_REQUIRE_ALL, 0);
      offer_track(track_at(3000, 3000, 1'b1));

      // Extreme settings: inverted box at the top plane, then the full box
      drain();
      write_settings(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      offer_track(random_track(1'b1));
      offer_track(random_track(1'b1));
      drain();
      write_settings(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      offer_track(random_track(1'b1));
      offer_track(random_track(1'b1));

      // Random events under a new cut setting per segment
      for (int seg = 0; seg < 9; seg++) begin
         if (seg == 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 26;
         end else if (seg == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         cx = spread(1 << 18);
         cy = spread(1 << 18);
         hx = $urandom_range(0, 1 << 16);
         hy = $urandom_range(0, 1 << 16);
         plane = spread(1 << 20);
         if (seg == 7) plane = COORD_MAX;
         else if (seg == 8) plane = COORD_MIN;
         if (seg == 2)
            write_settings(plane, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'(seg % 2));
         else if (seg == 5)
            write_settings(plane, cx + hx, cx - hx - 1, cy + hy, cy - hy - 1, 1'(seg % 2));
         else
            write_settings(plane, cx - hx, cx + hx, cy - hy, cy + hy, 1'(seg % 2));
         start = sent_tracks;
         while (sent_tracks - start < ITEMS_PER_SEGMENT) begin
            if ($urandom_range(99) < 6) offer_track(empty_item());
            else send_event($urandom_range(1, sb.require_all ? 3 : 4));
         end
      end

      // Hold off results long enough for the queue to fill and stall input
      drain();
      hold_cycles = HOLD_OFF_CYCLES;
      repeat (24) offer_track(random_track(1'b1));
      drain();

      if (sb.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
